/* rtl/core/trfa_pkg.sv */
// Shared types and constants for the lagged trace FIR accumulator.
// Used by the front, queue, back end and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trfa_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRACE_LEN = 2'd0;
  localparam logic [1:0] REG_TAP_COUNT = 2'd1;
  localparam logic [1:0] REG_LAG       = 2'd2;
  localparam logic [1:0] REG_START     = 2'd3;

  // Input opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Job queue between the front and the back end.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // Q16.16 rounded product width and reset values of the registers.
  localparam int RND_W = 48;
  localparam logic [16:0] TRACE_LEN_RST = 17'd1024;
  localparam logic [5:0]  TAP_COUNT_RST = 6'd1;

  typedef struct packed {
    logic [16:0] trace_len;
    logic [5:0]  tap_count;
    logic [15:0] lag;
    logic [15:0] start_cfg;
  } cfg_t;

  typedef struct packed {
    logic        is_sample;
    logic        emit;
    logic [4:0]  idx;
    logic [31:0] data;
    logic [31:0] prior;
    logic [15:0] position;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE  = 4'b0001,
    BK_MAC   = 4'b0010,
    BK_DRAIN = 4'b0100,
    BK_DONE  = 4'b1000
  } bk_state_t;

  typedef struct packed {
    bk_state_t state;
    logic      pop;
  } bk_stat_t;

endpackage

`default_nettype wire

/* rtl/core/trfa_front.sv */
// Front end: accepts requests, tracks the trace position and decides
// whether a sample produces an output. Depends on trfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trfa_front #(
  parameter int MAX_TRACE = 65536
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  op,
  input  wire  [4:0]           coef_index,
  input  wire  [31:0]          coef_value,
  input  wire  [31:0]          sample,
  input  wire  [31:0]          prior_out,
  input  trfa_pkg::cfg_t       cfg,
  input  wire                  q_full,
  output logic                 push,
  output trfa_pkg::job_t       job
);
  import trfa_pkg::*;

  localparam int LEN_W = $clog2(MAX_TRACE + 1);
  localparam int W     = ((LEN_W > 17) ? LEN_W : 17) + 2;
  localparam int POS_W = $clog2(MAX_TRACE);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [W-1:0]     len_raw;
  logic [W-1:0]     len_eff;
  logic [W-1:0]     j;
  logic [W-1:0]     j1;
  logic [W-1:0]     p;
  logic             emit;

  always_comb begin
    len_raw = W'(cfg.trace_len);
    if (len_raw == '0) begin
      len_eff = W'(1);
    end else if (len_raw > W'(MAX_TRACE)) begin
      len_eff = W'(MAX_TRACE);
    end else begin
      len_eff = len_raw;
    end
    // A position left beyond a shrunken trace restarts at zero.
    j  = (W'(pos) >= len_eff) ? '0 : W'(pos);
    j1 = j + W'(1);
    pos_next = (j1 >= len_eff) ? '0 : POS_W'(j1);
    p    = j + W'(cfg.lag);
    emit = (p >= W'(cfg.start_cfg)) && ((p + W'(cfg.lag)) < len_eff);
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    job.is_sample = (op == OP_SAMPLE);
    job.emit      = (op == OP_SAMPLE) && emit;
    job.idx       = coef_index;
    job.data      = (op == OP_SAMPLE) ? sample : coef_value;
    job.prior     = prior_out;
    job.position  = p[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push && op == OP_SAMPLE) begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/trfa_queue.sv */
// Short job queue that decouples the front from the back end.
// Depends on trfa_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module trfa_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  trfa_pkg::job_t       push_job,
  input  wire                  pop,
  output logic                 q_valid,
  output logic                 q_full,
  output trfa_pkg::job_t       head,
  output logic [trfa_pkg::QCW-1:0] count
);
  import trfa_pkg::*;

  job_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  assign q_valid = (count != '0);
  assign q_full  = (count == QCW'(QDEPTH));
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/trfa_back.sv */
// Back end: coefficient and delay line memories, the multiply-accumulate
// sequencer and the output register. Depends on trfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trfa_back #(
  parameter int MAX_TAPS = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  [5:0]           tap_count,
  input  wire                  q_valid,
  input  trfa_pkg::job_t       head,
  output trfa_pkg::bk_stat_t   stat,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [15:0]          position,
  output logic signed [31:0]   value
);
  import trfa_pkg::*;

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int IW    = ((TW > 6) ? TW : 6) + 1;
  localparam int ACC_W = RND_W + TW + 1;

  bk_state_t state;
  logic      pop;

  logic [31:0]         coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] coef_vld;
  logic [31:0]         dl_mem   [MAX_TAPS];

  logic [AW-1:0] wptr;
  logic [AW-1:0] rp;
  logic [AW-1:0] k;
  logic [TW-1:0] fill;
  logic [TW-1:0] taps_eff;
  logic [15:0]   pos_r;

  logic               s1_valid;
  logic               s2_valid;
  logic [31:0]        coef_rd;
  logic [31:0]        dl_rd;
  logic               cv_rd;
  logic               dv_rd;
  logic signed [31:0] a_op;
  logic signed [31:0] b_op;
  logic signed [63:0] prod;
  logic signed [63:0] prod_rnd;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] sat_val;
  logic               out_free;

  always_comb begin
    if (IW'(tap_count) > IW'(MAX_TAPS)) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = TW'(tap_count);
    end
  end

  assign pop      = (state == BK_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;
  assign stat     = '{state: state, pop: pop};

  // Round half up to Q16.16: the shifted value always fits in RND_W bits.
  assign prod_rnd = prod + 64'sd32768;
  assign a_op     = cv_rd ? signed'(coef_rd) : '0;
  assign b_op     = dv_rd ? signed'(dl_rd) : '0;

  always_comb begin
    if (acc[ACC_W-1:31] == {(ACC_W-31){acc[31]}}) begin
      sat_val = acc[31:0];
    end else if (acc[ACC_W-1]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7fff_ffff;
    end
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (pop && !head.is_sample && (IW'(head.idx) < IW'(MAX_TAPS))) begin
      coef_mem[AW'(head.idx)] <= head.data;
    end
    if (pop && head.is_sample) begin
      dl_mem[wptr] <= head.data;
    end
    coef_rd <= coef_mem[k];
    dl_rd   <= dl_mem[rp];
  end

  always_ff @(posedge clk) begin
    cv_rd <= coef_vld[k];
    dv_rd <= (TW'(k) < fill);
    prod  <= a_op * b_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      coef_vld  <= '0;
      wptr      <= '0;
      fill      <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == BK_MAC);
      s2_valid <= s1_valid;
      // A finished result may replace the one taken in the same cycle.
      if (out_valid && out_ready && (state != BK_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          if (pop && !head.is_sample) begin
            if (IW'(head.idx) < IW'(MAX_TAPS)) begin
              coef_vld[AW'(head.idx)] <= 1'b1;
            end
          end else if (pop) begin
            wptr <= (wptr == AW'(MAX_TAPS - 1)) ? '0 : wptr + 1'b1;
            if (fill != TW'(MAX_TAPS)) begin
              fill <= fill + 1'b1;
            end
            if (head.emit) begin
              state <= (taps_eff == '0) ? BK_DRAIN : BK_MAC;
            end
          end
        end
        BK_MAC: begin
          if (TW'(k) == taps_eff - 1'b1) begin
            state <= BK_DRAIN;
          end
        end
        BK_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            state <= BK_DONE;
          end
        end
        BK_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  // Tap index, read pointer and accumulator; no reset needed.
  always_ff @(posedge clk) begin
    if (pop && head.is_sample) begin
      k     <= '0;
      rp    <= wptr;
      pos_r <= head.position;
      acc   <= ACC_W'(signed'(head.prior));
    end else begin
      if (state == BK_MAC) begin
        k  <= k + 1'b1;
        rp <= (rp == '0) ? AW'(MAX_TAPS - 1) : rp - 1'b1;
      end
      if (s2_valid) begin
        acc <= acc + ACC_W'(signed'(prod_rnd[63:16]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_DONE && out_free) begin
      position <= pos_r;
      value    <= sat_val;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/trace_fir_accumulate_core.sv */
// Lagged FIR accumulator over seismic traces in Q16.16 fixed point.
//
// Input channel (in_valid/in_ready): op 0 loads coefficient coef_index with
// coef_value; op 1 presents a trace sample and the prior output at its
// lagged position. A sample whose output position falls in the computed
// window yields one result (position, value) on the output channel
// (out_valid/out_ready); loads and other samples yield nothing.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 trace_len, 1 tap_count, 2 lag, 3 start_cfg); write only while idle.
// A front stage takes one request per cycle, while the queue is not full,
// into a four-entry queue. The back end pops a load or a sample without
// output and stays idle; a sample with output passes through a pop, one
// multiply-accumulate per tap through a single 32x32 multiplier, a drain
// and a result step, and no job is popped until the result is registered.
// A zero tap count skips the multiply-accumulate step.
// The output register holds a result while the receiver stalls; the queue
// keeps taking requests until it fills. Reset clears coefficients, the
// delay line, the trace position and restores register defaults.
// Depends on trfa_pkg, trfa_front, trfa_queue and trfa_back.
`timescale 1ns / 1ps
`default_nettype none

module trace_fir_accumulate_core #(
  parameter int MAX_TAPS  = 32,
  parameter int MAX_TRACE = 65536
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [16:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                op,
  input  wire  [4:0]         coef_index,
  input  wire  signed [31:0] coef_value,
  input  wire  signed [31:0] sample,
  input  wire  signed [31:0] prior_out,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [15:0]        position,
  output logic signed [31:0] value
);
  import trfa_pkg::*;

  cfg_t           cfg;
  logic           push;
  job_t           push_job;
  logic           q_valid;
  logic           q_full;
  job_t           head;
  logic [QCW-1:0] q_count;
  bk_stat_t       bk_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trace_len <= TRACE_LEN_RST;
      cfg.tap_count <= TAP_COUNT_RST;
      cfg.lag       <= '0;
      cfg.start_cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRACE_LEN: cfg.trace_len <= cfg_data;
        REG_TAP_COUNT: cfg.tap_count <= cfg_data[5:0];
        REG_LAG:       cfg.lag       <= cfg_data[15:0];
        REG_START:     cfg.start_cfg <= cfg_data[15:0];
        default:       cfg           <= cfg;
      endcase
    end
  end

  trfa_front #(
    .MAX_TRACE (MAX_TRACE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .sample     (sample),
    .prior_out  (prior_out),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  trfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (bk_stat.pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head),
    .count    (q_count)
  );

  trfa_back #(
    .MAX_TAPS (MAX_TAPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tap_count (cfg.tap_count),
    .q_valid   (q_valid),
    .head      (head),
    .stat      (bk_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .value     (value)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QDEPTH))
    else $error("job queue count exceeds its depth");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    (bk_stat.state != BK_IDLE) |-> !bk_stat.pop)
    else $error("queue popped while the back end is busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bk_stat.state == BK_DONE))
    else $error("result presented without a finished accumulation");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (q_count == '0) |-> !bk_stat.pop)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

/* verif/trace_fir_accumulate_core_tb.sv */
// Self-checking testbench for trace_fir_accumulate_core, the lagged Q16.16 trace FIR.
// It needs only trfa_pkg and the core RTL: the stimulus, the filter arithmetic and
// the result checks all live in this file.
`timescale 1ns / 1ps

module trace_fir_accumulate_core_tb;
  import trfa_pkg::*;

  localparam int MAX_TAPS       = 32;
  localparam int MAX_TRACE      = 65536;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 5000;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_REQS     = 120;
  localparam longint SAT_HI     = 64'sd2147483647;
  localparam longint SAT_LO     = -64'sd2147483648;

  typedef struct packed {
    logic               op;
    logic [4:0]         idx;
    logic signed [31:0] coef;
    logic signed [31:0] smp;
    logic signed [31:0] prior;
  } trace_req_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [31:0] val;
  } fir_sum_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  trace_req_t  cur_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] position;
  logic signed [31:0] value;

  // Filter state kept by the testbench, mirroring what the core should hold.
  logic signed [31:0] coef_mem [MAX_TAPS] = '{default: '0};
  logic signed [31:0] tap_line [MAX_TAPS] = '{default: '0};
  int unsigned        trace_pos = 0;
  logic [16:0]        cf_len = 17'd1024;
  logic [5:0]         cf_taps = 6'd1;
  logic [15:0]        cf_lag = '0;
  logic [15:0]        cf_start = '0;

  trace_req_t trace_req_q [$];
  fir_sum_t   fir_sums_q [$];

  bit in_taken = 1'b0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int err_count = 0;
  int n_queued = 0;
  int n_reqs = 0;
  int n_loads = 0;
  int n_sums = 0;
  int n_settings = 0;

  trace_fir_accumulate_core #(
    .MAX_TAPS (MAX_TAPS),
    .MAX_TRACE(MAX_TRACE)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (cur_req.op),
    .coef_index(cur_req.idx),
    .coef_value(cur_req.coef),
    .sample    (cur_req.smp),
    .prior_out (cur_req.prior),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .value     (value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_trace_len(input logic [16:0] len);
    if (len == 0) return 1;
    if (len > MAX_TRACE) return MAX_TRACE;
    return len;
  endfunction

  // Q16.16 words biased toward the extremes and toward small magnitudes.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4, 5, 6: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // Applies one request to the filter state and queues the output, if any, that it produces.
  task automatic lagged_fir_update(input trace_req_t r);
    int unsigned len_eff;
    int unsigned taps_eff;
    int unsigned j;
    int unsigned p;
    longint      acc;
    longint      prod;
    fir_sum_t    res;
    if (r.op == OP_LOAD) begin
      coef_mem[r.idx] = r.coef;
      return;
    end
    len_eff = eff_trace_len(cf_len);
    taps_eff = (cf_taps > MAX_TAPS) ? MAX_TAPS : cf_taps;
    if (trace_pos >= len_eff) trace_pos = 0;
    j = trace_pos;
    trace_pos = (j + 1 >= len_eff) ? 0 : j + 1;
    for (int k = MAX_TAPS - 1; k > 0; k--) tap_line[k] = tap_line[k - 1];
    tap_line[0] = r.smp;
    p = j + cf_lag;
    if (p < cf_start || p + cf_lag >= len_eff) return;
    acc = longint'($signed(r.prior));
    for (int k = 0; k < taps_eff; k++) begin
      prod = longint'(coef_mem[k]) * longint'(tap_line[k]);
      acc += (prod + 64'sd32768) >>> 16;
    end
    res.pos = p[15:0];
    if (acc > SAT_HI) res.val = 32'h7FFF_FFFF;
    else if (acc < SAT_LO) res.val = 32'h8000_0000;
    else res.val = acc[31:0];
    fir_sums_q.push_back(res);
  endtask

  // Request driver: payload changes only on the falling edge after acceptance.
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (trace_req_q.size() > 0) begin
        cur_req <= trace_req_q.pop_front();
        in_valid <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      lagged_fir_update(cur_req);
      n_reqs++;
      if (cur_req.op == OP_LOAD) n_loads++;
      in_taken = 1'b1;
    end
  end

  // Result receiver, with random stalls and one long hold-off on request.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    fir_sum_t want;
    if (!rst && out_valid && out_ready) begin
      if (fir_sums_q.size() == 0) begin
        $display("%0t MISMATCH: unexpected result position=%0d value=%h",
                 $time, position, value);
        err_count++;
      end else begin
        want = fir_sums_q.pop_front();
        n_sums++;
        if (position !== want.pos) begin
          $display("%0t MISMATCH position: expected %0d, actual %0d",
                   $time, want.pos, position);
          err_count++;
        end
        if (value !== want.val) begin
          $display("%0t MISMATCH value at position %0d: expected %h, actual %h",
                   $time, want.pos, want.val, value);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t watchdog: no request or result moved for %0d cycles",
               $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_req(input logic op_v, input logic [4:0] idx_v,
                          input logic [31:0] coef_v, input logic [31:0] smp_v,
                          input logic [31:0] prior_v);
    trace_req_t r;
    r.op = op_v;
    r.idx = idx_v;
    r.coef = coef_v;
    r.smp = smp_v;
    r.prior = prior_v;
    trace_req_q.push_back(r);
    n_queued++;
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15)
        push_req(OP_LOAD, 5'($urandom), rand_coef(), $urandom(), $urandom());
      else
        push_req(OP_SAMPLE, 5'($urandom), $urandom(), rand_q(), rand_q());
    end
  endtask

  // Waits until every queued request has been accepted and every output has come
  // back, then lets the back end finish any trailing coefficient loads.
  task automatic settle();
    do @(negedge clk);
    while (n_reqs != n_queued || fir_sums_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [16:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_TRACE_LEN: cf_len = data;
      REG_TAP_COUNT: cf_taps = data[5:0];
      REG_LAG:       cf_lag = data[15:0];
      REG_START:     cf_start = data[15:0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the write data are randomized; the core must drop them.
  task automatic set_cfg(input logic [16:0] len, input logic [5:0] taps,
                         input logic [15:0] lg, input logic [15:0] st);
    settle();
    cfg_write(REG_TRACE_LEN, len);
    cfg_write(REG_TAP_COUNT, {11'($urandom), taps});
    cfg_write(REG_LAG, {1'($urandom), lg});
    cfg_write(REG_START, {1'($urandom), st});
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [16:0] r_len;
    logic [5:0]  r_taps;
    logic [15:0] r_lag;
    logic [15:0] r_start;
    int unsigned len_eff;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults: first sample sees all-zero taps, then rounding and
    // saturation at both ends with a single tap.
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h7FFF_FFFF, 32'h1234_5678);
    push_req(OP_LOAD, 5'd0, 32'h0001_0000, 32'h0, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h0001_8000, 32'h0);
    push_req(OP_LOAD, 5'd0, 32'h7FFF_FFFF, 32'h0, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h8000_0000, 32'h8000_0000);
    push_req(OP_LOAD, 5'd0, 32'h8000_0000, 32'h0, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h8000_0000, 32'h0);
    push_req(OP_LOAD, 5'd0, 32'h0000_8000, 32'h0, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h0000_0001, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    push_req(OP_LOAD, 5'd31, 32'hFFFF_FFFF, 32'h0, 32'h0);
    push_req(OP_LOAD, 5'd1, 32'h0002_0000, 32'h0, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);

    // Zero trace length behaves as one, and an oversized tap count as all taps.
    set_cfg(17'd0, 6'd63, 16'd0, 16'd0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h0003_0000, 32'h8000_0000);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'hFFFD_0000, 32'h0);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h5555_AAAA, 32'hAAAA_5555);
    push_req(OP_SAMPLE, 5'd0, 32'h0, 32'h0, 32'h0);

    // Oversized trace length with the lag past the end: nothing comes out.
    set_cfg(17'h1FFFF, 6'd0, 16'hFFFF, 16'hFFFF);
    repeat (5) push_req(OP_SAMPLE, 5'd0, 32'h0, rand_q(), rand_q());

    // Long trace with every tap, then a short trace so the position restarts.
    set_cfg(17'd1024, 6'd32, 16'd3, 16'd2);
    push_random(160);

    // The receiver holds off while requests keep coming, so the core backs up.
    set_cfg(17'd40, 6'd4, 16'd0, 16'd0);
    hold_req = 1'b1;
    push_random(60);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0: r_len = '0;
        1: r_len = 17'(65536 + $urandom_range(0, 65535));
        2, 3: r_len = 17'($urandom_range(65, 600));
        default: r_len = 17'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
        0: r_taps = '0;
        1: r_taps = 6'($urandom_range(33, 63));
        2: r_taps = 6'd32;
        default: r_taps = 6'($urandom_range(1, 16));
      endcase
      len_eff = eff_trace_len(r_len);
      if ($urandom_range(0, 9) == 0) r_lag = 16'($urandom);
      else r_lag = 16'($urandom_range(0, len_eff / 3));
      r_start = 16'($urandom_range(0, (len_eff - 1) / 2));
      set_cfg(r_len, r_taps, r_lag, r_start);
      // Every third phase and the last run without idling on either side.
      idle_en = (ph % 3 != 2) && (ph != RAND_PHASES - 1);
      push_random(PHASE_REQS);
    end

    settle();
    $display("Covered %0d requests (%0d coefficient loads) across %0d register settings;",
             n_reqs, n_loads, n_settings);
    $display("%0d filter outputs checked, %0d errors.", n_sums, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
